>>> rtl/slcfr_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte update for the frame receiver.
// Has no dependencies; every other file uses it through scoped names.
package slcfr_pkg;

   // Frame layout
   localparam int unsigned HEADER_BYTES          = 6;
   localparam int unsigned MAX_PAYLOAD_BOUND_DEF = 255;

   // Position codes that carry special meaning
   localparam logic [8:0] POS_HUNT   = 9'd0;
   localparam logic [8:0] POS_SYNC2  = 9'd1;
   localparam logic [8:0] POS_LENGTH = 9'(HEADER_BYTES - 1);

   // CRC-16/XMODEM polynomial
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Item kinds
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_SYNC_FIRST    = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND   = 2'd1;
   localparam logic [1:0] CSR_MAX_PAYLOAD   = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd3;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   // Configuration reset values
   localparam logic [7:0]  SYNC_FIRST_RST    = 8'd0;
   localparam logic [7:0]  SYNC_SECOND_RST   = 8'd0;
   localparam logic [7:0]  MAX_PAYLOAD_RST   = 8'd255;
   localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000;

   localparam logic [31:0] TICKS_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [8:0] byte_index;
      logic       frame_done;
      logic       frame_good;
      logic       frame_abort;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [7:0]  max_payload;
      logic [31:0] timeout_ticks;
   } cfg_type;

   // One byte of CRC-16/XMODEM, MSB first, all eight shifts unrolled
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

>>> rtl/slcfr_csr.sv
// Configuration registers of the frame receiver: sync values, length limit, timeout.
// Depends on slcfr_pkg.
module slcfr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [slcfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [slcfr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output slcfr_pkg::cfg_type                   cfg
);

   slcfr_pkg::cfg_type cfg_ff;
   slcfr_pkg::cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            slcfr_pkg::CSR_SYNC_FIRST:    cfg_in.sync_first    = csr_wdata[7:0];
            slcfr_pkg::CSR_SYNC_SECOND:   cfg_in.sync_second   = csr_wdata[7:0];
            slcfr_pkg::CSR_MAX_PAYLOAD:   cfg_in.max_payload   = csr_wdata[7:0];
            slcfr_pkg::CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[31:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first    <= slcfr_pkg::SYNC_FIRST_RST;
         cfg_ff.sync_second   <= slcfr_pkg::SYNC_SECOND_RST;
         cfg_ff.max_payload   <= slcfr_pkg::MAX_PAYLOAD_RST;
         cfg_ff.timeout_ticks <= slcfr_pkg::TIMEOUT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/slcfr_parse.sv
// Frame state and the combinational step logic: sync hunt, length check, CRC, timeout.
// Depends on slcfr_pkg.
module slcfr_parse #(
   parameter int unsigned MAX_PAYLOAD_BOUND = slcfr_pkg::MAX_PAYLOAD_BOUND_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  slcfr_pkg::req_word_type step_word,
   input  slcfr_pkg::cfg_type      cfg,
   output logic                    res_valid,
   output slcfr_pkg::rsp_word_type res_word
);

   localparam logic [7:0] BOUND = 8'(MAX_PAYLOAD_BOUND);

   logic [8:0]  position_ff,  position_in;
   logic [7:0]  plen_ff,      plen_in;
   logic [15:0] crc_ff,       crc_in;
   logic [7:0]  crc_low_ff,   crc_low_in;
   logic [31:0] elapsed_ff,   elapsed_in;

   logic [7:0]  u;
   logic [7:0]  limit;
   logic [7:0]  plen_eff;
   logic [8:0]  crc_at;
   logic [8:0]  total;
   logic [8:0]  pos_next;
   logic [31:0] elapsed_inc;

   assign u           = step_word.rx_byte;
   assign limit       = (cfg.max_payload < BOUND) ? cfg.max_payload : BOUND;
   assign plen_eff    = (position_ff == slcfr_pkg::POS_LENGTH) ? u : plen_ff;
   assign crc_at      = 9'(slcfr_pkg::HEADER_BYTES) + {1'b0, plen_eff};
   assign total       = crc_at + 9'd2;
   assign pos_next    = position_ff + 9'd1;
   assign elapsed_inc = (elapsed_ff == slcfr_pkg::TICKS_MAX) ? elapsed_ff
                                                             : elapsed_ff + 32'd1;

   // Step one item through the frame state
   always_comb begin
      position_in = position_ff;
      plen_in     = plen_ff;
      crc_in      = crc_ff;
      crc_low_in  = crc_low_ff;
      elapsed_in  = elapsed_ff;
      res_valid   = 1'b0;
      res_word    = '0;
      res_word.data_byte  = u;
      res_word.byte_index = position_ff;

      if (step_en) begin
         if (step_word.func == slcfr_pkg::FUNC_TICK) begin
            // Count ticks inside a frame; drop it past the timeout
            if (position_ff != slcfr_pkg::POS_HUNT) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc > cfg.timeout_ticks) begin
                  position_in          = slcfr_pkg::POS_HUNT;
                  res_valid            = 1'b1;
                  res_word.data_byte   = 8'd0;
                  res_word.frame_abort = 1'b1;
               end
            end
         end else if (position_ff == slcfr_pkg::POS_HUNT) begin
            // Hunt for the first sync byte
            if (u == cfg.sync_first) begin
               elapsed_in  = 32'd0;
               plen_in     = 8'd0;
               crc_low_in  = 8'd0;
               crc_in      = slcfr_pkg::crc_byte(16'd0, u);
               position_in = slcfr_pkg::POS_SYNC2;
               res_valid   = 1'b1;
            end
         end else if (position_ff == slcfr_pkg::POS_SYNC2 && u != cfg.sync_second) begin
            // Bad second sync: drop without rechecking this byte
            position_in          = slcfr_pkg::POS_HUNT;
            res_valid            = 1'b1;
            res_word.frame_abort = 1'b1;
         end else if (position_ff == slcfr_pkg::POS_LENGTH && u > limit) begin
            // Length over the limit
            position_in          = slcfr_pkg::POS_HUNT;
            res_valid            = 1'b1;
            res_word.frame_abort = 1'b1;
         end else begin
            // Header, payload or CRC byte
            plen_in   = plen_eff;
            res_valid = 1'b1;
            if (position_ff < crc_at) begin
               crc_in = slcfr_pkg::crc_byte(crc_ff, u);
            end else if (position_ff == crc_at) begin
               crc_low_in = u;
            end
            if (pos_next >= total) begin
               position_in         = slcfr_pkg::POS_HUNT;
               res_word.frame_done = 1'b1;
               res_word.frame_good = (plen_eff != 8'd0) && ({u, crc_low_ff} == crc_ff);
            end else begin
               position_in = pos_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= slcfr_pkg::POS_HUNT;
         plen_ff     <= 8'd0;
         crc_ff      <= 16'd0;
         crc_low_ff  <= 8'd0;
         elapsed_ff  <= 32'd0;
      end else begin
         position_ff <= position_in;
         plen_ff     <= plen_in;
         crc_ff      <= crc_in;
         crc_low_ff  <= crc_low_in;
         elapsed_ff  <= elapsed_in;
      end
   end

endmodule

>>> rtl/sync_length_crc_frame_receiver_core.sv
// Top level of the sync/length/CRC frame receiver: input register, step logic, result register.
// Depends on slcfr_pkg, slcfr_csr and slcfr_parse.

// Takes one word per cycle while the result side does not stall, either a received byte or a
// time tick, and returns at most one result word per input word. Each word passes through an
// input register, the step logic (byte-wide CRC-16/XMODEM update, position and length checks,
// 32-bit timeout compare) and a result register. The CRC byte update against the stored frame
// state sets the clock period. Words that cause no result still pass the step logic in order.
// Configuration is written through the csr_ port; the user must write it only while the
// receiver is idle, as the block itself does not enforce this.
module sync_length_crc_frame_receiver_core #(
   parameter int unsigned MAX_PAYLOAD_BOUND = slcfr_pkg::MAX_PAYLOAD_BOUND_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  slcfr_pkg::req_word_type           req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output slcfr_pkg::rsp_word_type           rsp_word,
   input  logic                              csr_we,
   input  logic [slcfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slcfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   slcfr_pkg::cfg_type      cfg;
   logic                    in_valid_ff;
   slcfr_pkg::req_word_type in_word_ff;
   logic                    out_valid_ff;
   slcfr_pkg::rsp_word_type out_word_ff;
   logic                    advance;
   logic                    res_valid;
   slcfr_pkg::rsp_word_type res_word;

   slcfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Advance the held word when the result register has room
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   slcfr_parse #(
      .MAX_PAYLOAD_BOUND (MAX_PAYLOAD_BOUND)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_word (in_word_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_word_ff <= req_word;
      end
   end

   // Result register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_word_ff <= res_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

>>> rtl/slcfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
// Depends on slcfr_pkg and sync_length_crc_frame_receiver_core.
module slcfr_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input slcfr_pkg::rsp_word_type rsp_word
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed or vanished");

   // Good only on a finished frame
   a_good_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.frame_good |-> rsp_word.frame_done)
      else $error("frame_good without frame_done");

   // Done and abort are exclusive
   a_done_abort: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.frame_done && rsp_word.frame_abort))
      else $error("frame_done and frame_abort together");

   // Shortest frame ends at index 7
   a_done_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.frame_done |-> rsp_word.byte_index >= 9'd7)
      else $error("frame_done before the end of header and CRC");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sync_length_crc_frame_receiver_core slcfr_checker u_slcfr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
